// ===== sv/ptc_pkg.sv =====
// ============================================================================
// ptc_pkg - shared types and constants for the compensation core
// Calibration layout, a division helper, register indexes and pipeline transfer types.
// ============================================================================
package ptc_pkg;

    localparam int unsigned DIV_STEPS = 32;

    typedef enum logic [1:0] {
        REG_CAL_TEMP       = 2'd0,
        REG_CAL_PRESS_LOW  = 2'd1,
        REG_CAL_PRESS_HIGH = 2'd2,
        REG_CAL_PRESS_LAST = 2'd3
    } t_reg_index;

    typedef struct packed {
        logic [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } t_cal;

    // item after the front part: temperature done, fine temperature and raw pressure carried on
    typedef struct packed {
        logic signed [31:0] temp;
        logic signed [31:0] fine;
        logic [19:0]        adc_p;
    } t_front_item;

    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] press;
    } t_result;

    // signed division by 2^n, truncating toward zero
    function automatic logic signed [31:0] tdiv_pow2(input logic signed [31:0] a,
                                                     input int unsigned n);
        logic signed [31:0] bias;
        bias = a[31] ? ((32'sd1 <<< n) - 32'sd1) : 32'sd0;
        return (a + bias) >>> n;
    endfunction

endpackage

// ===== sv/ptc_stream_if.sv =====
// ============================================================================
// ptc_stream_if - valid/ready channel
// Carries one payload of parameterised width with a source and a sink view.
// ============================================================================
interface ptc_stream_if #(
    parameter int unsigned WIDTH = 40
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/ptc_front.sv =====
// ============================================================================
// ptc_front - temperature compensation pipeline
// Four register stages compute fine temperature and temperature; stalls as one.
// ============================================================================
module ptc_front
    import ptc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cal        i_cal,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [19:0] i_raw_t,
    input  logic [19:0] i_raw_p,
    output logic        o_valid,
    input  logic        i_ready,
    output t_front_item o_item
);
    logic [3:0] r_v;
    logic       adv;

    logic signed [31:0] r_a0, r_d0;
    logic [19:0]        r_p0, r_p1, r_p2, r_p3;
    logic signed [31:0] r_am1, r_dd1;
    logic signed [31:0] r_a2, r_b2m;
    logic signed [31:0] r_fine3, r_temp3;

    logic signed [31:0] adc_t, t1, n_a0, n_d0, dd_s, fine, temp5;

    assign adv     = !r_v[3] || i_ready;
    assign o_ready = adv;
    assign o_valid = r_v[3];
    assign o_item  = '{temp: r_temp3, fine: r_fine3, adc_p: r_p3};

    always_comb begin
        adc_t = {12'd0, i_raw_t};
        t1    = {16'd0, i_cal.t1};
        n_a0  = (adc_t >>> 3) - (t1 <<< 1);
        n_d0  = (adc_t >>> 4) - t1;
        dd_s  = r_dd1 >>> 12;
        fine  = (r_a2 + (r_b2m >>> 14));
        temp5 = fine * 32'sd5 + 32'sd128;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a0    <= n_a0;
            r_d0    <= n_d0;
            r_p0    <= i_raw_p;
            r_am1   <= r_a0 * 32'(i_cal.t2);
            r_dd1   <= r_d0 * r_d0;
            r_p1    <= r_p0;
            r_a2    <= r_am1 >>> 11;
            r_b2m   <= dd_s * 32'(i_cal.t3);
            r_p2    <= r_p1;
            r_fine3 <= fine;
            r_temp3 <= temp5 >>> 8;
            r_p3    <= r_p2;
        end
    end
endmodule

// ===== sv/ptc_queue.sv =====
// ============================================================================
// ptc_queue - short FIFO between the front and back parts
// Register-based, power-of-two depth, full/empty from a fill count.
// ============================================================================
module ptc_queue
    import ptc_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_front_item i_item,
    output logic        o_valid,
    input  logic        i_ready,
    output t_front_item o_item
);
    localparam int unsigned AW = $clog2(DEPTH);

    t_front_item       r_mem [DEPTH];
    logic [AW-1:0]     r_wp, r_rp;
    logic [AW:0]       r_cnt;
    logic              push, pop;

    assign o_ready = (r_cnt != (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_item;
    end
endmodule

// ===== sv/ptc_back.sv =====
// ============================================================================
// ptc_back - pressure compensation pipeline
// Term stages, a pipelined restoring divider and the final correction stages.
// ============================================================================
module ptc_back
    import ptc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cal        i_cal,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_front_item i_item,
    output logic        o_valid,
    input  logic        i_ready,
    output t_result     o_res
);
    // stage map: 0..4 terms, 5..36 divider, 37..39 correction
    localparam int unsigned NS = 5 + DIV_STEPS + 3;

    logic [NS-1:0] r_v;
    logic          adv;

    assign adv     = !r_v[NS-1] || i_ready;
    assign o_ready = adv;
    assign o_valid = r_v[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    // ---- term stages ----
    logic signed [31:0] s0_a, s0_a4, s0_temp;
    logic [19:0]        s0_adcp;
    logic signed [31:0] s1_q, s1_a, s1_p5a, s1_p2a, s1_temp;
    logic [19:0]        s1_adcp;
    logic signed [31:0] s2_b6, s2_b5, s2_a3, s2_a2, s2_q, s2_temp;
    logic [19:0]        s2_adcp;
    logic signed [31:0] s3_b, s3_am, s3_temp;
    logic [19:0]        s3_adcp;
    logic signed [31:0] s4_pm, s4_div, s4_temp;

    logic signed [31:0] a_n, b3_n, a3_n, a4_n;

    always_comb begin
        a_n  = tdiv_pow2(i_item.fine, 1) - 32'sd64000;
        b3_n = tdiv_pow2(s2_b6 + (s2_b5 <<< 1), 2) + (32'(i_cal.p4) <<< 16);
        a3_n = tdiv_pow2(tdiv_pow2(s2_a3, 3) + tdiv_pow2(s2_a2, 1), 18) + 32'sd32768;
        a4_n = tdiv_pow2(s3_am, 15);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            s0_a    <= a_n;
            s0_a4   <= tdiv_pow2(a_n, 2);
            s0_temp <= i_item.temp;
            s0_adcp <= i_item.adc_p;

            s1_q    <= s0_a4 * s0_a4;
            s1_a    <= s0_a;
            s1_p5a  <= s0_a * 32'(i_cal.p5);
            s1_p2a  <= s0_a * 32'(i_cal.p2);
            s1_temp <= s0_temp;
            s1_adcp <= s0_adcp;

            s2_b6   <= tdiv_pow2(s1_q, 11) * 32'(i_cal.p6);
            s2_b5   <= s1_p5a;
            s2_a3   <= 32'(i_cal.p3) * tdiv_pow2(s1_q, 13);
            s2_a2   <= s1_p2a;
            s2_q    <= s1_q;
            s2_temp <= s1_temp;
            s2_adcp <= s1_adcp;

            s3_b    <= b3_n;
            s3_am   <= a3_n * $signed({16'd0, i_cal.p1});
            s3_temp <= s2_temp;
            s3_adcp <= s2_adcp;

            s4_pm   <= ((32'sd1048576 - $signed({12'd0, s3_adcp})) - tdiv_pow2(s3_b, 12))
                       * 32'sd3125;
            s4_div  <= a4_n;
            s4_temp <= s3_temp;
        end
    end

    // ---- restoring divider, one quotient bit per stage ----
    logic [31:0] d_num  [DIV_STEPS+1];
    logic [31:0] d_rem  [DIV_STEPS+1];
    logic [31:0] d_quo  [DIV_STEPS+1];
    logic [31:0] d_div  [DIV_STEPS+1];
    logic        d_big  [DIV_STEPS+1];
    logic [31:0] d_temp [DIV_STEPS+1];

    logic [31:0] pm_u;
    assign pm_u = s4_pm;

    always_comb begin
        d_big[0]  = pm_u[31];
        d_num[0]  = pm_u[31] ? pm_u : (pm_u << 1);
        d_rem[0]  = '0;
        d_quo[0]  = '0;
        d_div[0]  = s4_div;
        d_temp[0] = s4_temp;
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        logic [32:0] trial, diff;
        logic [31:0] r_num, r_rem, r_quo, r_div, r_temp;
        logic        r_big;
        always_comb begin
            trial = {d_rem[k], d_num[k][31]};
            diff  = trial - {1'b0, d_div[k]};
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_num  <= d_num[k] << 1;
                r_rem  <= diff[32] ? trial[31:0] : diff[31:0];
                r_quo  <= {d_quo[k][30:0], !diff[32]};
                r_div  <= d_div[k];
                r_big  <= d_big[k];
                r_temp <= d_temp[k];
            end
        end
        assign d_num[k+1]  = r_num;
        assign d_rem[k+1]  = r_rem;
        assign d_quo[k+1]  = r_quo;
        assign d_div[k+1]  = r_div;
        assign d_big[k+1]  = r_big;
        assign d_temp[k+1] = r_temp;
    end

    // ---- correction stages ----
    logic [31:0]        c0_p, c0_e, c0_temp;
    logic               c0_zero;
    logic signed [31:0] c1_ap, c1_bp, c1_p;
    logic [31:0]        c1_temp;
    logic               c1_zero;
    logic [31:0]        c2_p, c2_temp;
    logic [31:0]        e_n, p_n, quo;
    logic signed [31:0] sum_n;

    always_comb begin
        quo   = d_quo[DIV_STEPS];
        p_n   = d_big[DIV_STEPS] ? (quo << 1) : quo;
        e_n   = {3'd0, p_n[31:3]} * {3'd0, p_n[31:3]};
        sum_n = c1_p + tdiv_pow2(tdiv_pow2(c1_ap, 12) + tdiv_pow2(c1_bp, 13)
                                 + 32'(i_cal.p7), 4);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            c0_p    <= p_n;
            c0_e    <= e_n;
            c0_zero <= (d_div[DIV_STEPS] == '0);
            c0_temp <= d_temp[DIV_STEPS];

            c1_ap   <= 32'(i_cal.p9) * $signed({13'd0, c0_e[31:13]});
            c1_bp   <= $signed({2'd0, c0_p[31:2]}) * 32'(i_cal.p8);
            c1_p    <= c0_p;
            c1_zero <= c0_zero;
            c1_temp <= c0_temp;

            c2_p    <= c1_zero ? 32'd0 : sum_n;
            c2_temp <= c1_temp;
        end
    end

    assign o_res = '{temp: c2_temp, press: c2_p};
endmodule

// ===== sv/pressure_temperature_compensation_core.sv =====
// ============================================================================
// pressure_temperature_compensation_core - 32-bit integer sensor compensation
// Temperature front pipeline, queue, pressure back pipeline with divider.
// ============================================================================
// Register stages from input to result with the queue empty: 45 (4 front,
// 1 queue, 40 back incl. 32-stage divider).
// Throughput: one item per cycle while the output is ready; every stage, the divider included, is pipelined.
// Reset: synchronous active low; clears pipeline valids and the queue,
// calibration registers reset to zero.
module pressure_temperature_compensation_core
    import ptc_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    ptc_stream_if.sink   i_in,
    ptc_stream_if.source o_out
);
    logic [47:0] r_cal0;
    logic [63:0] r_cal1, r_cal2;
    logic [15:0] r_cal3;
    t_cal        cal;
    t_reg_index  idx;
    logic        wr;

    assign pready = 1'b1;
    assign idx    = t_reg_index'(paddr[4:3]);
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal0 <= '0;
            r_cal1 <= '0;
            r_cal2 <= '0;
            r_cal3 <= '0;
        end else if (wr) begin
            unique case (idx)
                REG_CAL_TEMP:       r_cal0 <= pwdata[47:0];
                REG_CAL_PRESS_LOW:  r_cal1 <= pwdata;
                REG_CAL_PRESS_HIGH: r_cal2 <= pwdata;
                REG_CAL_PRESS_LAST: r_cal3 <= pwdata[15:0];
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_CAL_TEMP:       prdata = {16'd0, r_cal0};
            REG_CAL_PRESS_LOW:  prdata = r_cal1;
            REG_CAL_PRESS_HIGH: prdata = r_cal2;
            REG_CAL_PRESS_LAST: prdata = {48'd0, r_cal3};
        endcase
    end

    assign cal = '{t1: r_cal0[15:0], t2: r_cal0[31:16], t3: r_cal0[47:32],
                   p1: r_cal1[15:0], p2: r_cal1[31:16], p3: r_cal1[47:32],
                   p4: r_cal1[63:48], p5: r_cal2[15:0], p6: r_cal2[31:16],
                   p7: r_cal2[47:32], p8: r_cal2[63:48], p9: r_cal3};

    logic        f_v, f_r, q_v, q_r;
    t_front_item f_item, q_item;
    t_result     res;

    ptc_front u_front (
        .i_clk, .i_rst_n, .i_cal(cal),
        .i_valid(i_in.valid), .o_ready(i_in.ready),
        .i_raw_t(i_in.data[19:0]), .i_raw_p(i_in.data[39:20]),
        .o_valid(f_v), .i_ready(f_r), .o_item(f_item)
    );

    ptc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk, .i_rst_n,
        .i_valid(f_v), .o_ready(f_r), .i_item(f_item),
        .o_valid(q_v), .i_ready(q_r), .o_item(q_item)
    );

    ptc_back u_back (
        .i_clk, .i_rst_n, .i_cal(cal),
        .i_valid(q_v), .o_ready(q_r), .i_item(q_item),
        .o_valid(o_out.valid), .i_ready(o_out.ready), .o_res(res)
    );

    assign o_out.data = {res.press, res.temp};
endmodule

// ===== sv/ptc_checker.sv =====
// ============================================================================
// ptc_checker - port-level checks for the compensation core
// Handshake and configuration port properties, bound to the top level.
// ============================================================================
module ptc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        pready,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] out_data
);
    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("result valid after reset");

    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !out_valid)
        else $error("result before any transfer");

    // a pending input transfer is never withdrawn
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("input valid dropped while stalled");
endmodule

bind pressure_temperature_compensation_core ptc_checker u_ptc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .pready(pready),
    .in_valid(i_in.valid), .in_ready(i_in.ready),
    .out_valid(o_out.valid), .out_ready(o_out.ready), .out_data(o_out.data)
);

// ===== bench/tb_top.sv =====
// ============================================================================
// tb_top - regression bench for the compensation core
// Programs calibration over APB, streams raw sample pairs with random stalls
// on both channels and checks every result against an in-bench predictor.
// ============================================================================
module tb_top;
    import ptc_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic pready;

    ptc_stream_if #(.WIDTH(40)) in_ch ();
    ptc_stream_if #(.WIDTH(64)) out_ch ();

    pressure_temperature_compensation_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    always #5 i_clk = ~i_clk;

    localparam int LIMIT = 1000000;

    logic [47:0] cal_t;
    logic [63:0] cal_pl, cal_ph;
    logic [15:0] cal_p9;
    logic [63:0] expected_results[$];
    int errors = 0;
    int cycles = 0;
    int src_idle = 0, snk_idle = 0;

    // truncating division by 2^n, magnitude taken unsigned so -2^31 is exact
    function automatic logic signed [31:0] sdiv(logic signed [31:0] a, int n);
        logic [31:0] m;
        m = a[31] ? -a : a;
        m = m >> n;
        return a[31] ? -m : m;
    endfunction

    function automatic logic [63:0] compensate(logic [19:0] rt, logic [19:0] rp);
        logic signed [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic signed [31:0] adc_t, adc_p, a, b, fine, temp, q, d;
        logic [31:0] p, dv, e;
        t1 = {16'd0, cal_t[15:0]};
        t2 = $signed(cal_t[31:16]);
        t3 = $signed(cal_t[47:32]);
        p1 = {16'd0, cal_pl[15:0]};
        p2 = $signed(cal_pl[31:16]);
        p3 = $signed(cal_pl[47:32]);
        p4 = $signed(cal_pl[63:48]);
        p5 = $signed(cal_ph[15:0]);
        p6 = $signed(cal_ph[31:16]);
        p7 = $signed(cal_ph[47:32]);
        p8 = $signed(cal_ph[63:48]);
        p9 = $signed(cal_p9);
        adc_t = {12'd0, rt};
        adc_p = {12'd0, rp};
        a = (((adc_t >>> 3) - (t1 <<< 1)) * t2) >>> 11;
        d = (adc_t >>> 4) - t1;
        b = (((d * d) >>> 12) * t3) >>> 14;
        fine = a + b;
        temp = (fine * 5 + 128) >>> 8;
        a = sdiv(fine, 1) - 64000;
        q = sdiv(a, 2) * sdiv(a, 2);
        b = sdiv(q, 11) * p6;
        b = b + a * p5 * 2;
        b = sdiv(b, 2) + (p4 <<< 16);
        a = sdiv(sdiv(p3 * sdiv(q, 13), 3) + sdiv(p2 * a, 1), 18);
        a = sdiv((32'sd32768 + a) * p1, 15);
        p = ((32'sd1048576 - adc_p) - sdiv(b, 12)) * 32'sd3125;
        if (a != 0) begin
            dv = a;
            if (p < 32'h8000_0000) p = (p << 1) / dv;
            else p = (p / dv) * 2;
            e = (p / 8) * (p / 8);
            a = sdiv(p9 * $signed(e / 8192), 12);
            b = sdiv($signed(p / 4) * p8, 13);
            p = $signed(p) + sdiv(a + b + p7, 4);
        end else begin
            p = 0;
        end
        return {p, temp};
    endfunction

    task automatic apb_write(t_reg_index idx, logic [63:0] val);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= 5'(idx) << 3; pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_CAL_TEMP:       cal_t = val[47:0];
            REG_CAL_PRESS_LOW:  cal_pl = val;
            REG_CAL_PRESS_HIGH: cal_ph = val;
            default:            cal_p9 = val[15:0];
        endcase
    endtask

    task automatic program_cal(logic [47:0] t, logic [63:0] pl, logic [63:0] ph,
                               logic [15:0] p9);
        apb_write(REG_CAL_TEMP, {16'd0, t});
        apb_write(REG_CAL_PRESS_LOW, pl);
        apb_write(REG_CAL_PRESS_HIGH, ph);
        apb_write(REG_CAL_PRESS_LAST, {48'd0, p9});
    endtask

    // typed expectation is checked against the predictor only when use_typed is set
    task automatic send_sample(logic [19:0] rt, logic [19:0] rp, logic [63:0] typed,
                               bit use_typed);
        logic [63:0] want;
        want = compensate(rt, rp);
        if (use_typed && typed != want) begin
            $error("table row: expected %h predictor %h", typed, want);
            errors++;
        end
        while ($urandom_range(99) < src_idle) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= {rp, rt};
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        expected_results.push_back(want);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    function automatic logic [47:0] r48();
        return 48'({$urandom(), $urandom()});
    endfunction
    function automatic logic [63:0] r64();
        return {$urandom(), $urandom()};
    endfunction

    // random calibration: mostly typical of real parts with noise, one time in four fully random
    task automatic random_cal();
        if ($urandom_range(3) == 0)
            program_cal(r48(), r64(), r64(), 16'($urandom()));
        else
            program_cal({16'($urandom_range(50) - 25), 16'($urandom_range(30000, 20000)),
                         16'($urandom_range(32000, 24000))},
                        {16'($urandom_range(9000, 1000)), 16'($urandom_range(9000, 1000)),
                         16'(-$urandom_range(12000, 9000)), 16'($urandom_range(40000, 30000))},
                        {16'(-$urandom_range(20)), 16'($urandom_range(800)),
                         16'($urandom_range(-100 & 65535)), 16'(-$urandom_range(9000))},
                        16'($urandom_range(8000)));
    endtask

    always @(posedge i_clk) begin
        logic [63:0] want;
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result %h", out_ch.data);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (out_ch.data[31:0] !== want[31:0]) begin
                    $error("temperature_centi expected %h got %h", want[31:0],
                           out_ch.data[31:0]);
                    errors++;
                end
                if (out_ch.data[63:32] !== want[63:32]) begin
                    $error("pressure_pascal expected %h got %h", want[63:32],
                           out_ch.data[63:32]);
                    errors++;
                end
            end
        end
    end

    always @(negedge i_clk)
        out_ch.ready <= ($urandom_range(99) >= snk_idle);

    typedef struct {
        logic [19:0] rt;
        logic [19:0] rp;
        logic [63:0] res;
        bit          typed;
    } t_row;

    initial begin
        t_row rows[$];
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        cal_t = '0; cal_pl = '0; cal_ph = '0; cal_p9 = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // zero calibration: fine = 0, temp = 0, divisor term 0 gives pressure 0
        rows.push_back('{20'd0, 20'd0, 64'd0, 1'b1});
        rows.push_back('{20'hFFFFF, 20'hFFFFF, 64'd0, 1'b1});
        rows.push_back('{20'hFFFFF, 20'd0, 64'd0, 1'b1});
        foreach (rows[i]) send_sample(rows[i].rt, rows[i].rp, rows[i].res, rows[i].typed);
        drain();
        rows.delete();
        // typical calibration, then extremes of each register
        program_cal({16'hFC18, 16'd26435, 16'd27504}, {16'd8000, -16'sd10, 16'hD8BA, 16'd36477},
                    {16'd7, 16'hFFF9, 16'd140, -16'sd7}, 16'd6000);
        rows.push_back('{20'd519888, 20'd415148, 64'd0, 1'b0});
        rows.push_back('{20'd0, 20'd0, 64'd0, 1'b0});
        rows.push_back('{20'hFFFFF, 20'hFFFFF, 64'd0, 1'b0});
        rows.push_back('{20'h80000, 20'h00001, 64'd0, 1'b0});
        rows.push_back('{20'h7FFFF, 20'hFFFFE, 64'd0, 1'b0});
        foreach (rows[i]) send_sample(rows[i].rt, rows[i].rp, rows[i].res, rows[i].typed);
        drain();
        program_cal('1, '1, '1, 16'hFFFF);
        foreach (rows[i]) send_sample(rows[i].rt, rows[i].rp, rows[i].res, rows[i].typed);
        drain();
        program_cal(48'h8000_8000_8000, 64'h8000_8000_8000_8000,
                    64'h8000_8000_8000_8000, 16'h8000);
        foreach (rows[i]) send_sample(rows[i].rt, rows[i].rp, rows[i].res, rows[i].typed);
        drain();
        program_cal(48'h7FFF_7FFF_FFFF, 64'h7FFF_7FFF_7FFF_FFFF,
                    64'h7FFF_7FFF_7FFF_7FFF, 16'h7FFF);
        foreach (rows[i]) send_sample(rows[i].rt, rows[i].rp, rows[i].res, rows[i].typed);
        drain();
        for (int ph = 0; ph < 3; ph++) begin
            src_idle = (ph == 0) ? 18 : (ph == 1) ? 73 : 0;
            snk_idle = (ph == 0) ? 73 : (ph == 1) ? 18 : 0;
            for (int blk = 0; blk < 5; blk++) begin
                random_cal();
                for (int n = 0; n < 103; n++)
                    send_sample(20'($urandom()), 20'($urandom()), '0, 1'b0);
                drain();
            end
        end
        if (errors == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end
endmodule
